/* rtl/core/dat_pkg.sv */
// ----------------------------------------------------------------------------
// dat_pkg
// Types and constants shared by the device address table modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dat_pkg;

    localparam int SLOT_W       = 4;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Operation codes on the input channel.
    localparam logic [2:0] OP_UPSERT     = 3'd0;
    localparam logic [2:0] OP_REMOVE     = 3'd1;
    localparam logic [2:0] OP_FIND_LONG  = 3'd2;
    localparam logic [2:0] OP_FIND_SHORT = 3'd3;
    localparam logic [2:0] OP_ADD_CAP    = 3'd4;
    localparam logic [2:0] OP_ADD_EP     = 3'd5;

    // Status codes on the result channel.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_IGNORED   = 2'd3;

    localparam logic [7:0] MAX_ONOFF_EP = 8'd32;
    localparam logic [7:0] PREFERRED_EP = 8'd1;

    // Command kinds after classification by the front end.
    typedef logic [2:0] t_kind;
    localparam t_kind K_UPSERT     = 3'd0;
    localparam t_kind K_REMOVE     = 3'd1;
    localparam t_kind K_FIND_LONG  = 3'd2;
    localparam t_kind K_FIND_SHORT = 3'd3;
    localparam t_kind K_ADD_CAP    = 3'd4;
    localparam t_kind K_ADD_EP     = 3'd5;
    localparam t_kind K_BAD_SLOT   = 3'd6;
    localparam t_kind K_BAD_OP     = 3'd7;

    typedef struct packed {
        logic [2:0]        operation;
        logic [63:0]       long_address;
        logic [15:0]       short_address;
        logic [7:0]        endpoint_number;
        logic [7:0]        capability_bits;
        logic [SLOT_W-1:0] slot_index;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        status;
        logic [SLOT_W-1:0] result_slot;
        logic [63:0]       result_long_address;
        logic [15:0]       result_short_address;
        logic [7:0]        result_endpoint;
        logic [7:0]        result_capabilities;
        logic [31:0]       result_onoff_mask;
        logic              created;
        logic              changed;
    } t_result;

    typedef struct packed {
        t_kind             kind;
        logic [63:0]       long_address;
        logic [15:0]       short_address;
        logic [7:0]        endpoint_number;
        logic [7:0]        capability_bits;
        logic [SLOT_W-1:0] slot_index;
    } t_cmd;

    typedef struct packed {
        logic [63:0] long_address;
        logic [15:0] short_address;
        logic [7:0]  endpoint;
        logic [7:0]  capabilities;
        logic [31:0] onoff_mask;
    } t_entry;

endpackage

`default_nettype wire

/* rtl/core/device_address_table.sv */
// ----------------------------------------------------------------------------
// device_address_table
// Associative table of network devices keyed by 64-bit long address.
// ----------------------------------------------------------------------------
// Usage: operations enter through a queue-style port (push/full) and every
// operation yields exactly one result on a queue-style port (empty/pop). The
// oldest result is shown while empty is low and leaves on pop.
// An input stage decodes each transaction into a command queue; the table
// engine takes one command at a time, so a stalled result port only stops the
// engine once the result queue is full, while input continues into the queue.
// Timing: upsert, remove and the two lookups scan the slots one per cycle
// through the registered read port of the entry memory, ending early on a
// hit. Add capability and add endpoint read the addressed slot, then write
// it back; ignored operations finish without touching the table. The engine
// takes a new transaction only once it is done with the last one.
// Reset: synchronous, active low. All valid bits clear at once, so the table
// is empty as soon as reset is released; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module device_address_table
    import dat_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     push,
    input  wire t_in_item i_item,
    output logic          full,
    output logic          empty,
    input  wire logic     pop,
    output t_result       o_result
);

    logic                    q_push;
    t_cmd                    q_cmd_in;
    logic                    q_full;
    logic [$bits(t_cmd)-1:0] q_data_out;
    logic                    q_empty;
    logic                    cmd_pop;
    logic                    res_full;
    logic                    res_push;
    t_result                 res;
    logic [$bits(t_result)-1:0] res_data_out;

    dat_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (i_item),
        .o_full   (full),
        .o_q_push (q_push),
        .o_q_cmd  (q_cmd_in),
        .i_q_full (q_full)
    );

    dat_fifo #(
        .WIDTH ($bits(t_cmd))
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_cmd_in),
        .o_full  (q_full),
        .i_pop   (cmd_pop),
        .o_data  (q_data_out),
        .o_empty (q_empty)
    );

    dat_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (t_cmd'(q_data_out)),
        .i_cmd_empty (q_empty),
        .o_cmd_pop   (cmd_pop),
        .i_res_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    dat_fifo #(
        .WIDTH ($bits(t_result))
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_data_out),
        .o_empty (empty)
    );

    assign o_result = t_result'(res_data_out);

endmodule

`default_nettype wire

/* rtl/core/dat_fifo.sv */
// ----------------------------------------------------------------------------
// dat_fifo
// Short register queue used between the front end, the back end and the
// result port.
// ----------------------------------------------------------------------------
`default_nettype none

module dat_fifo
    import dat_pkg::*;
#(
    parameter int WIDTH = 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    logic [WIDTH-1:0]  r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/dat_front.sv */
// ----------------------------------------------------------------------------
// dat_front
// Input stage: takes a transaction, decodes the operation and checks the
// slot number and endpoint, then hands a command to the command queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dat_front
    import dat_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_in_item i_item,
    output logic          o_full,
    output logic          o_q_push,
    output t_cmd          o_q_cmd,
    input  wire logic     i_q_full
);

    logic  r_vld;
    t_cmd  r_cmd;
    t_cmd  n_cmd;
    logic  accept;
    logic  slot_ok;
    logic  ep_ok;

    assign o_q_push = r_vld && !i_q_full;
    assign o_full   = r_vld && i_q_full;
    assign accept   = i_push && !o_full;
    assign o_q_cmd  = r_cmd;

    assign slot_ok = (32'(i_item.slot_index) < TABLE_DEPTH);
    assign ep_ok   = (i_item.endpoint_number != 8'd0) &&
                     (i_item.endpoint_number <= MAX_ONOFF_EP);

    always_comb begin
        n_cmd.long_address    = i_item.long_address;
        n_cmd.short_address   = i_item.short_address;
        n_cmd.endpoint_number = i_item.endpoint_number;
        n_cmd.capability_bits = i_item.capability_bits;
        n_cmd.slot_index      = i_item.slot_index;
        unique case (i_item.operation)
            OP_UPSERT:     n_cmd.kind = K_UPSERT;
            OP_REMOVE:     n_cmd.kind = K_REMOVE;
            OP_FIND_LONG:  n_cmd.kind = K_FIND_LONG;
            OP_FIND_SHORT: n_cmd.kind = K_FIND_SHORT;
            OP_ADD_CAP:    n_cmd.kind = slot_ok ? K_ADD_CAP : K_BAD_SLOT;
            OP_ADD_EP:     n_cmd.kind = (slot_ok && ep_ok) ? K_ADD_EP : K_BAD_SLOT;
            default:       n_cmd.kind = K_BAD_OP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (accept) begin
            r_vld <= 1'b1;
        end else if (o_q_push) begin
            r_vld <= 1'b0;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/dat_back.sv */
// ----------------------------------------------------------------------------
// dat_back
// Table engine: holds the entry memory and valid bits, scans the slots one
// per cycle for lookups, upserts and removes, and updates addressed slots.
// ----------------------------------------------------------------------------
`default_nettype none

module dat_back
    import dat_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire logic i_cmd_empty,
    output logic      o_cmd_pop,
    input  wire logic i_res_full,
    output logic      o_res_push,
    output t_result   o_res
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_SLOT = 2'd2;

    t_entry                 r_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;
    logic [1:0]             r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic [CW-1:0]          r_scan_cnt, n_scan_cnt;
    logic                   r_cmp_pend, n_cmp_pend;
    logic [IW-1:0]          r_cmp_idx, n_cmp_idx;
    logic                   r_free_found, n_free_found;
    logic [IW-1:0]          r_free_idx, n_free_idx;
    t_entry                 r_rd_data;

    logic          rd_en;
    logic [IW-1:0] rd_addr;
    logic          wr_en;
    logic [IW-1:0] wr_addr;
    t_entry        wr_data;
    logic          hit;
    logic [IW-1:0] slot_addr;
    t_entry        upd;
    logic [31:0]   ep_bit;
    logic          take_ep;

    function automatic t_result make_result(logic [1:0] st, logic [IW-1:0] idx, t_entry e,
                                            logic cr, logic ch);
        t_result r;
        r.status               = st;
        r.result_slot          = SLOT_W'(idx);
        r.result_long_address  = e.long_address;
        r.result_short_address = e.short_address;
        r.result_endpoint      = e.endpoint;
        r.result_capabilities  = e.capabilities;
        r.result_onoff_mask    = e.onoff_mask;
        r.created              = cr;
        r.changed              = ch;
        return r;
    endfunction

    function automatic t_result ignored_result(logic [SLOT_W-1:0] slot);
        t_result r;
        r             = '0;
        r.status      = ST_IGNORED;
        r.result_slot = slot;
        return r;
    endfunction

    assign slot_addr = IW'(i_cmd.slot_index);
    assign hit = r_cmp_pend && r_valid[r_cmp_idx] &&
                 ((r_cmd.kind == K_FIND_SHORT) ?
                  (r_rd_data.short_address == r_cmd.short_address) :
                  (r_rd_data.long_address == r_cmd.long_address));
    assign ep_bit  = 32'd1 << r_cmd.endpoint_number[4:0] - 5'd1;
    assign take_ep = (r_rd_data.endpoint == 8'd0) ||
                     (r_cmd.endpoint_number == PREFERRED_EP) ||
                     ((r_rd_data.endpoint != PREFERRED_EP) &&
                      (r_cmd.endpoint_number < r_rd_data.endpoint));

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_scan_cnt   = r_scan_cnt;
        n_cmp_pend   = 1'b0;
        n_cmp_idx    = r_cmp_idx;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_valid      = r_valid;
        rd_en        = 1'b0;
        rd_addr      = r_scan_cnt[IW-1:0];
        wr_en        = 1'b0;
        wr_addr      = r_cmp_idx;
        wr_data      = r_rd_data;
        upd          = r_rd_data;
        o_cmd_pop    = 1'b0;
        o_res_push   = 1'b0;
        o_res        = '0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    n_cmd     = i_cmd;
                    unique case (i_cmd.kind)
                        K_UPSERT, K_REMOVE, K_FIND_LONG, K_FIND_SHORT: begin
                            n_state      = S_SCAN;
                            n_scan_cnt   = '0;
                            n_free_found = 1'b0;
                        end
                        K_ADD_CAP, K_ADD_EP: begin
                            if (r_valid[slot_addr]) begin
                                rd_en     = 1'b1;
                                rd_addr   = slot_addr;
                                n_cmp_idx = slot_addr;
                                n_state   = S_SLOT;
                            end else begin
                                o_res_push = 1'b1;
                                o_res      = ignored_result(i_cmd.slot_index);
                            end
                        end
                        K_BAD_SLOT: begin
                            o_res_push = 1'b1;
                            o_res      = ignored_result(i_cmd.slot_index);
                        end
                        default: begin
                            o_res_push = 1'b1;
                            o_res      = ignored_result('0);
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (hit) begin
                    // The lowest matching slot ends the scan.
                    n_state    = S_IDLE;
                    o_res_push = 1'b1;
                    if (r_cmd.kind == K_UPSERT) begin
                        upd.short_address = r_cmd.short_address;
                        if (r_cmd.endpoint_number != 8'd0) begin
                            upd.endpoint = r_cmd.endpoint_number;
                        end
                        wr_en   = 1'b1;
                        wr_data = upd;
                    end else if (r_cmd.kind == K_REMOVE) begin
                        n_valid[r_cmp_idx] = 1'b0;
                    end
                    o_res = make_result(ST_OK, r_cmp_idx, upd, 1'b0, 1'b0);
                end else if (!r_cmp_pend && (r_scan_cnt == CW'(TABLE_DEPTH))) begin
                    n_state    = S_IDLE;
                    o_res_push = 1'b1;
                    if (r_cmd.kind != K_UPSERT) begin
                        o_res.status = ST_NOT_FOUND;
                    end else if (!r_free_found) begin
                        o_res.status = ST_FULL;
                    end else begin
                        upd.long_address  = r_cmd.long_address;
                        upd.short_address = r_cmd.short_address;
                        upd.endpoint      = r_cmd.endpoint_number;
                        upd.capabilities  = '0;
                        upd.onoff_mask    = '0;
                        wr_en   = 1'b1;
                        wr_addr = r_free_idx;
                        wr_data = upd;
                        n_valid[r_free_idx] = 1'b1;
                        o_res = make_result(ST_OK, r_free_idx, upd, 1'b1, 1'b0);
                    end
                end else begin
                    if (r_cmp_pend && !r_valid[r_cmp_idx] && !r_free_found) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_cmp_idx;
                    end
                    if (r_scan_cnt < CW'(TABLE_DEPTH)) begin
                        rd_en      = 1'b1;
                        rd_addr    = r_scan_cnt[IW-1:0];
                        n_scan_cnt = r_scan_cnt + 1'b1;
                        n_cmp_pend = 1'b1;
                        n_cmp_idx  = r_scan_cnt[IW-1:0];
                    end
                end
            end
            S_SLOT: begin
                n_state    = S_IDLE;
                o_res_push = 1'b1;
                wr_en      = 1'b1;
                if (r_cmd.kind == K_ADD_CAP) begin
                    upd.capabilities = r_rd_data.capabilities | r_cmd.capability_bits;
                    o_res = make_result(ST_OK, r_cmp_idx, upd, 1'b0,
                                        upd.capabilities != r_rd_data.capabilities);
                end else begin
                    upd.onoff_mask = r_rd_data.onoff_mask | ep_bit;
                    if (take_ep) begin
                        upd.endpoint = r_cmd.endpoint_number;
                    end
                    o_res = make_result(ST_OK, r_cmp_idx, upd, 1'b0,
                                        upd.onoff_mask != r_rd_data.onoff_mask);
                end
                wr_data = upd;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_cmp_idx  <= n_cmp_idx;
        r_free_idx <= n_free_idx;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= '0;
            r_scan_cnt   <= '0;
            r_cmp_pend   <= 1'b0;
            r_free_found <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_scan_cnt   <= n_scan_cnt;
            r_cmp_pend   <= n_cmp_pend;
            r_free_found <= n_free_found;
        end
    end

    // A result is only produced when the result queue has room for it.
    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !i_res_full)
        else $error("result produced while result queue is full");

    // Every table write completes an operation and produces its result.
    a_wr_with_res: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> o_res_push && (n_state == S_IDLE))
        else $error("table write without a result");

    // The scan never runs past the end of the table.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_scan_cnt <= CW'(TABLE_DEPTH))
        else $error("scan counter beyond table depth");

    // A new command is taken only when the engine is idle.
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |-> (r_state == S_IDLE) && !i_cmd_empty)
        else $error("command taken while engine busy");

endmodule

`default_nettype wire

/* dv/tb_device_address_table.sv */
// ----------------------------------------------------------------------------
// tb_device_address_table
// Self-checking testbench for the device address table. Every accepted
// operation is run through a shadow copy of the table, and each result
// popped from the block is compared field by field with the oldest
// prediction. Directed operations cover the corner cases first. Random
// traffic follows in phases of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_device_address_table
    import dat_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS = 16;
    localparam int NUM_KEYS  = 20;
    localparam int NUM_SHORT = 6;

    // Operation codes the block does not define; both must be ignored.
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    class table_scoreboard;
        logic    valid[NUM_SLOTS];
        t_entry  rows[NUM_SLOTS];
        t_result pending_results[$];
        int      errors;
        int      checked;
        int      status_seen[4];

        function new();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                clear_row(i);
            end
            errors  = 0;
            checked = 0;
            for (int i = 0; i < 4; i++) begin
                status_seen[i] = 0;
            end
        endfunction

        function void clear_row(int s);
            valid[s] = 1'b0;
            rows[s]  = '0;
        endfunction

        function int find_long(logic [63:0] key);
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (valid[i] && rows[i].long_address == key) return i;
            end
            return -1;
        endfunction

        function int find_short(logic [15:0] key);
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (valid[i] && rows[i].short_address == key) return i;
            end
            return -1;
        endfunction

        function int find_free();
            for (int i = 0; i < NUM_SLOTS; i++) begin
                if (!valid[i]) return i;
            end
            return -1;
        endfunction

        function t_result with_row(t_result r, int s);
            r.result_slot          = s[SLOT_W-1:0];
            r.result_long_address  = rows[s].long_address;
            r.result_short_address = rows[s].short_address;
            r.result_endpoint      = rows[s].endpoint;
            r.result_capabilities  = rows[s].capabilities;
            r.result_onoff_mask    = rows[s].onoff_mask;
            return r;
        endfunction

        function t_result predict_table_op(t_in_item it);
            t_result     r;
            int          s;
            logic [7:0]  cur;
            logic [7:0]  cap_before;
            logic [31:0] mask_before;
            r = '0;
            unique case (it.operation)
                OP_UPSERT: begin
                    s = find_long(it.long_address);
                    if (s < 0) begin
                        s = find_free();
                        if (s < 0) begin
                            r.status = ST_FULL;
                            return r;
                        end
                        clear_row(s);
                        valid[s] = 1'b1;
                        rows[s].long_address = it.long_address;
                        r.created = 1'b1;
                    end
                    rows[s].short_address = it.short_address;
                    if (it.endpoint_number != 8'd0) rows[s].endpoint = it.endpoint_number;
                    r = with_row(r, s);
                    r.status = ST_OK;
                end
                OP_REMOVE, OP_FIND_LONG, OP_FIND_SHORT: begin
                    s = (it.operation == OP_FIND_SHORT) ? find_short(it.short_address)
                                                        : find_long(it.long_address);
                    if (s < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r = with_row(r, s);
                        r.status = ST_OK;
                        // A remove reports the entry as it stood before clearing.
                        if (it.operation == OP_REMOVE) clear_row(s);
                    end
                end
                OP_ADD_CAP, OP_ADD_EP: begin
                    s = int'(it.slot_index);
                    if (!valid[s]) begin
                        r.status      = ST_IGNORED;
                        r.result_slot = it.slot_index;
                    end else if (it.operation == OP_ADD_CAP) begin
                        cap_before = rows[s].capabilities;
                        rows[s].capabilities = cap_before | it.capability_bits;
                        r.changed = (rows[s].capabilities != cap_before);
                        r = with_row(r, s);
                        r.status = ST_OK;
                    end else if (it.endpoint_number < 8'd1 ||
                                 it.endpoint_number > MAX_ONOFF_EP) begin
                        r.status      = ST_IGNORED;
                        r.result_slot = it.slot_index;
                    end else begin
                        mask_before = rows[s].onoff_mask;
                        rows[s].onoff_mask = mask_before |
                                             (32'd1 << (it.endpoint_number - 8'd1));
                        cur = rows[s].endpoint;
                        // The primary moves even when the mask bit was already set.
                        if (cur == 8'd0 || it.endpoint_number == PREFERRED_EP ||
                            (cur != PREFERRED_EP && it.endpoint_number < cur)) begin
                            rows[s].endpoint = it.endpoint_number;
                        end
                        r.changed = (rows[s].onoff_mask != mask_before);
                        r = with_row(r, s);
                        r.status = ST_OK;
                    end
                end
                default: begin
                    r.status = ST_IGNORED;
                end
            endcase
            return r;
        endfunction

        function void note_item(t_in_item it);
            pending_results.push_back(predict_table_op(it));
        endfunction

        function void compare_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result with nothing expected, actual %0h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            checked++;
            status_seen[want.status]++;
            compare_field("status", 64'(want.status), 64'(got.status));
            compare_field("result_slot", 64'(want.result_slot), 64'(got.result_slot));
            compare_field("result_long_address", want.result_long_address,
                          got.result_long_address);
            compare_field("result_short_address", 64'(want.result_short_address),
                          64'(got.result_short_address));
            compare_field("result_endpoint", 64'(want.result_endpoint),
                          64'(got.result_endpoint));
            compare_field("result_capabilities", 64'(want.result_capabilities),
                          64'(got.result_capabilities));
            compare_field("result_onoff_mask", 64'(want.result_onoff_mask),
                          64'(got.result_onoff_mask));
            compare_field("created", 64'(want.created), 64'(got.created));
            compare_field("changed", 64'(want.changed), 64'(got.changed));
        endfunction
    endclass

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     push    = 1'b0;
    logic     pop     = 1'b0;
    t_in_item i_item  = '0;
    logic     full;
    logic     empty;
    t_result  o_result;

    table_scoreboard sb = new();

    int          idle_pct   = 0;
    int          stall_pct  = 0;
    int          items_sent = 0;
    logic [63:0] key_pool[NUM_KEYS];
    logic [15:0] short_pool[NUM_SHORT];

    device_address_table #(
        .TABLE_DEPTH(NUM_SLOTS)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .i_item  (i_item),
        .full    (full),
        .empty   (empty),
        .pop     (pop),
        .o_result(o_result)
    );

    always #2 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        pop <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            sb.check_result(o_result);
        end
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic t_in_item mk(logic [2:0] op, logic [63:0] la, logic [15:0] sa,
                                    logic [7:0] ep, logic [7:0] cap, logic [3:0] slot);
        t_in_item it;
        it.operation       = op;
        it.long_address    = la;
        it.short_address   = sa;
        it.endpoint_number = ep;
        it.capability_bits = cap;
        it.slot_index      = slot;
        return it;
    endfunction

    function automatic logic [3:0] pick_slot();
        int picks[$];
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (sb.valid[i]) picks.push_back(i);
        end
        if (picks.size() == 0 || $urandom_range(0, 99) < 15) return 4'($urandom_range(0, 15));
        return 4'(picks[$urandom_range(0, picks.size() - 1)]);
    endfunction

    function automatic logic [7:0] pick_onoff_ep();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return 8'($urandom_range(1, 32));
        if (r < 90) return 8'd0;
        return 8'($urandom_range(33, 255));
    endfunction

    function automatic t_in_item make_random_item();
        t_in_item it;
        int       r;
        r = $urandom_range(0, 99);
        it.long_address    = ($urandom_range(0, 9) == 0) ? {$urandom, $urandom}
                                                         : key_pool[$urandom_range(0, NUM_KEYS-1)];
        it.short_address   = ($urandom_range(0, 9) < 7) ? short_pool[$urandom_range(0, NUM_SHORT-1)]
                                                        : 16'($urandom);
        it.capability_bits = ($urandom_range(0, 1) == 0) ? 8'($urandom)
                                                         : 8'd1 << $urandom_range(0, 7);
        it.slot_index      = pick_slot();
        it.endpoint_number = ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom);
        if (r < 30)      it.operation = OP_UPSERT;
        else if (r < 42) it.operation = OP_REMOVE;
        else if (r < 57) it.operation = OP_FIND_LONG;
        else if (r < 69) it.operation = OP_FIND_SHORT;
        else if (r < 81) it.operation = OP_ADD_CAP;
        else if (r < 96) begin
            it.operation       = OP_ADD_EP;
            it.endpoint_number = pick_onoff_ep();
        end else begin
            it.operation = ($urandom_range(0, 1) == 0) ? OP_SPARE_6 : OP_SPARE_7;
        end
        return it;
    endfunction

    // Presents one transaction, with an optional idle gap first, and records it
    // once the block accepts it. push stays high when items follow back to back.
    task automatic send_item(input t_in_item it);
        if ($urandom_range(0, 99) < idle_pct) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
        @(negedge i_clk);
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        push <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_device_join();
        logic [63:0] key;
        logic [15:0] sa;
        int          s;
        key = key_pool[$urandom_range(0, NUM_KEYS-1)];
        sa  = short_pool[$urandom_range(0, NUM_SHORT-1)];
        send_item(mk(OP_UPSERT, key, sa, ($urandom_range(0, 1) == 0) ? 8'd0 : 8'($urandom),
                     8'd0, 4'd0));
        s = sb.find_long(key);
        if (s < 0) return;
        repeat ($urandom_range(1, 3)) begin
            send_item(mk(OP_ADD_EP, key, sa, pick_onoff_ep(), 8'd0, 4'(s)));
        end
        send_item(mk(OP_ADD_CAP, key, sa, 8'd0, 8'($urandom), 4'(s)));
        send_item(mk(OP_FIND_LONG, key, sa, 8'd0, 8'd0, 4'd0));
        send_item(mk(OP_FIND_SHORT, key, sa, 8'd0, 8'd0, 4'd0));
    endtask

    initial begin
        int          target;
        int          r;
        int          k0;
        logic [63:0] ones;

        ones = '1;
        for (int i = 0; i < NUM_KEYS; i++) begin
            key_pool[i] = {$urandom, $urandom};
        end
        key_pool[0] = '0;
        key_pool[1] = ones;
        for (int i = 0; i < NUM_SHORT; i++) begin
            short_pool[i] = 16'($urandom);
        end
        short_pool[0] = 16'h0000;
        short_pool[1] = 16'hFFFF;

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corner cases, starting from the empty table.
        send_item(mk(OP_FIND_LONG, 64'd0, 16'd0, 8'd0, 8'd0, 4'd0));
        send_item(mk(OP_FIND_SHORT, 64'd0, 16'd0, 8'd0, 8'd0, 4'd0));
        send_item(mk(OP_ADD_CAP, 64'd0, 16'd0, 8'd0, 8'hFF, 4'd0));
        send_item(mk(OP_UPSERT, 64'd0, 16'hFFFF, 8'd0, 8'd0, 4'd0));
        send_item(mk(OP_UPSERT, ones, 16'h0000, 8'hFF, 8'd0, 4'd0));
        send_item(mk(OP_UPSERT, 64'd0, 16'h1234, 8'hFF, 8'd0, 4'hF));
        send_item(mk(OP_ADD_CAP, 64'd0, 16'd0, 8'd0, 8'hFF, 4'd0));
        send_item(mk(OP_ADD_CAP, 64'd0, 16'd0, 8'd0, 8'h0F, 4'd0));
        send_item(mk(OP_ADD_EP, 64'd0, 16'd0, 8'd0, 8'd0, 4'd1));
        send_item(mk(OP_ADD_EP, 64'd0, 16'd0, 8'd33, 8'd0, 4'd1));
        send_item(mk(OP_ADD_EP, 64'd0, 16'd0, 8'd255, 8'd0, 4'd1));
        send_item(mk(OP_ADD_EP, 64'd0, 16'd0, 8'd32, 8'd0, 4'd1));
        send_item(mk(OP_ADD_EP, 64'd0, 16'd0, 8'd1, 8'd0, 4'd1));
        send_item(mk(OP_ADD_EP, 64'd0, 16'd0, 8'd5, 8'd0, 4'd1));
        send_item(mk(OP_ADD_EP, 64'd0, 16'd0, 8'd1, 8'd0, 4'd1));
        send_item(mk(OP_ADD_EP, 64'd0, 16'd0, 8'd3, 8'd0, 4'hF));
        send_item(mk(OP_FIND_SHORT, 64'd0, 16'h0000, 8'd0, 8'd0, 4'd0));
        send_item(mk(OP_FIND_SHORT, 64'd0, 16'h1234, 8'd0, 8'd0, 4'd0));
        send_item(mk(OP_FIND_LONG, ones, 16'd0, 8'd0, 8'd0, 4'd0));
        send_item(mk(OP_SPARE_6, ones, 16'hFFFF, 8'hFF, 8'hFF, 4'hF));
        send_item(mk(OP_SPARE_7, ones, 16'hFFFF, 8'hFF, 8'hFF, 4'hF));
        send_item(mk(OP_REMOVE, ones, 16'd0, 8'd0, 8'd0, 4'd0));
        send_item(mk(OP_REMOVE, ones, 16'd0, 8'd0, 8'd0, 4'd0));

        // Random traffic in four phases of sender idling and receiver stalling.
        for (int phase = 0; phase < 4; phase++) begin
            unique case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 56; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 56; end
                default: begin idle_pct = 12; stall_pct = 12; end
            endcase
            if (phase != 0) wait_drained();
            target = 23 + 410 * (phase + 1);
            while (items_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 6) begin
                    // Upserting the whole key pool overflows the table.
                    k0 = $urandom_range(0, NUM_KEYS-1);
                    for (int i = 0; i < NUM_KEYS; i++) begin
                        send_item(mk(OP_UPSERT, key_pool[(k0 + i) % NUM_KEYS],
                                     short_pool[$urandom_range(0, NUM_SHORT-1)],
                                     8'($urandom), 8'd0, 4'd0));
                    end
                end else if (r < 10) begin
                    for (int i = 0; i < NUM_KEYS; i++) begin
                        send_item(mk(OP_REMOVE, key_pool[i], 16'd0, 8'd0, 8'd0, 4'd0));
                    end
                end else if (r < 13) begin
                    // Retire a key before replacing it so that its slot does not stay taken.
                    k0 = $urandom_range(0, NUM_KEYS-1);
                    send_item(mk(OP_REMOVE, key_pool[k0], 16'd0, 8'd0, 8'd0, 4'd0));
                    key_pool[k0] = {$urandom, $urandom};
                end else if (r < 25) begin
                    run_device_join();
                end else if (r < 33) begin
                    send_item(mk(3'($urandom_range(0, 7)), {$urandom, $urandom}, 16'($urandom),
                                 8'($urandom), 8'($urandom), 4'($urandom)));
                end else begin
                    send_item(make_random_item());
                end
            end
        end

        wait_drained();
        repeat (64) @(posedge i_clk);

        $display("Ran %0d transactions in four idle/stall phases; checked %0d results.",
                 items_sent, sb.checked);
        $display("Results seen: %0d ok, %0d not found, %0d table full, %0d ignored.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_NOT_FOUND],
                 sb.status_seen[ST_FULL], sb.status_seen[ST_IGNORED]);
        if (sb.errors == 0 && sb.pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
